// ----- rtl/assert_macros.svh -----
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the clustering block.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of aclk while aresetn is high.
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/lcc_pkg.sv -----
//------------------------------------------------------------------------------
// lcc_pkg
// Types and fixed constants shared by the leader clustering block.
//------------------------------------------------------------------------------
package lcc_pkg;

    // Register file layout.
    localparam int EPS_W     = 38;
    localparam int DIMS_W    = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = EPS_W;

    localparam logic [CFG_IDX_W-1:0] REG_EPS_SQUARED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = CFG_IDX_W'(1);

    // Squared distances saturate at the top of this width.
    localparam int ACC_W = 64;

    // Result word layout.
    localparam int COUNT_W    = 7;
    localparam int OUT_W      = 16;
    localparam int BIT_KEPT   = 0;
    localparam int BIT_COUNT  = 1;
    localparam int BIT_FULL   = BIT_COUNT + COUNT_W;

    // Tags that travel with each element through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first_dim;
        logic last_dim;
        logic last_center;
    } dist_ctl_t;

    // One verdict per center.
    typedef struct packed {
        logic valid;
        logic far;
        logic last_center;
    } dist_res_t;

endpackage

// ----- rtl/lcc_dist_unit.sv -----
//------------------------------------------------------------------------------
// lcc_dist_unit
// Pipelined difference, square and saturating accumulate for one coordinate
// per cycle, with the threshold compare at the last coordinate of a center.
//------------------------------------------------------------------------------
module lcc_dist_unit
    import lcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dist_ctl_t                     ctl_i,
    input  logic signed [COORD_WIDTH-1:0] point_i,
    input  logic signed [COORD_WIDTH-1:0] center_i,
    input  logic [EPS_W-1:0]              eps_i,
    output dist_res_t                     res_o
);

    localparam int SQ_W = 2 * COORD_WIDTH;

    dist_ctl_t              ctl_c_reg;
    dist_ctl_t              ctl_d_reg;
    dist_res_t              res_reg;
    logic [COORD_WIDTH-1:0] abs_c_reg;
    logic [SQ_W-1:0]        sq_d_reg;
    logic [ACC_W-1:0]       acc_reg;

    logic [COORD_WIDTH:0]   diff;
    logic [COORD_WIDTH:0]   mag;
    logic [SQ_W-1:0]        sq;
    logic [ACC_W-1:0]       base;
    logic [ACC_W:0]         sum;
    logic [ACC_W-1:0]       sat;

    // The difference of two coordinates needs one extra bit; its magnitude
    // fits back into the coordinate width.
    always_comb begin
        diff = {point_i[COORD_WIDTH-1], point_i} - {center_i[COORD_WIDTH-1], center_i};
        mag  = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;
    end

    assign sq = abs_c_reg * abs_c_reg;

    always_comb begin
        base = ctl_d_reg.first_dim ? '0 : acc_reg;
        sum  = {1'b0, base} + (ACC_W + 1)'(sq_d_reg);
        sat  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            res_reg   <= '0;
        end else begin
            ctl_c_reg         <= ctl_i;
            ctl_d_reg         <= ctl_c_reg;
            res_reg.valid     <= ctl_d_reg.valid && ctl_d_reg.last_dim;
            res_reg.far       <= sat > ACC_W'(eps_i);
            res_reg.last_center <= ctl_d_reg.last_center;
        end
    end

    always_ff @(posedge aclk) begin
        abs_c_reg <= mag[COORD_WIDTH-1:0];
        sq_d_reg  <= sq;
        if (ctl_d_reg.valid) begin
            acc_reg <= sat;
        end
    end

    assign res_o = res_reg;

endmodule

// ----- rtl/leader_clustering_centers.sv -----
//------------------------------------------------------------------------------
// leader_clustering_centers
// Greedy leader clustering over a stream of point coordinates, with the
// center store held in an on-chip memory and one shared distance pipeline.
//------------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Content
// s_       in   s_tvalid/s_tready    tdata: coordinate; tuser: first_of_set
// m_       out  m_tvalid/m_tready    tdata: kept, center_count, store_full
// cfg_     in   cfg_valid/cfg_ready  cfg_index selects register, cfg_data value
//
// A coordinate that does not finish a point is taken in the idle state. A word
// that finishes a point with N centers held and D dimensions in use starts a
// scan of N*D elements, set by the single read port of the center memory that
// feeds one squared difference per cycle, then drains the distance pipeline and
// decides; with no centers held the scan and the drain are skipped. A kept point
// is then written as a new center over all MAX_DIM slots; the result register is loaded.
// Reset is synchronous and active low; the center memory needs no clearing.
// A stalled result word waits in the output register; the input takes new
// words meanwhile and halts only while a point is scanned or stored, or while
// a further result waits to go out.
//
module leader_clustering_centers
    import lcc_pkg::*;
#(
    parameter int MAX_CENTERS = 64,
    parameter int MAX_DIM     = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input words.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Bits from lowest: coordinate (COORD_WIDTH, signed), zero fill.
    input  logic [((COORD_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    // Bit 0: first_of_set.
    input  logic [0:0]                             s_tuser,
    // Result words.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Bits from lowest: kept (1), center_count (7), store_full (1), zero fill.
    output logic [OUT_W-1:0]                       m_tdata,
    // Register writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DAT_W-1:0]                   cfg_data
);

    // Widths that follow from the parameters.
    localparam int DI_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DC_W  = $clog2(MAX_DIM + 1);
    localparam int CI_W  = $clog2(MAX_CENTERS);
    localparam int HC_W  = $clog2(MAX_CENTERS + 1);
    localparam int MEM_D = MAX_CENTERS * (2 ** DI_W);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_STORE  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;

    logic [EPS_W-1:0]       eps_reg;
    logic [DIMS_W-1:0]      dims_reg;

    logic [DI_W-1:0]        coord_cnt_reg;
    logic [HC_W-1:0]        held_reg;
    logic [CI_W-1:0]        scan_c_reg;
    logic [DI_W-1:0]        scan_i_reg;
    logic [DI_W-1:0]        store_i_reg;
    logic [DI_W-1:0]        pt_i_reg;
    logic                   far_reg;
    logic                   kept_reg;
    logic                   full_reg;
    dist_ctl_t              ctl_b_reg;
    dist_ctl_t              ctl_b_next;

    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;

    // Current point and center store.
    logic signed [COORD_WIDTH-1:0] pbuf_reg [MAX_DIM];
    logic signed [COORD_WIDTH-1:0] cmem     [MEM_D];
    logic signed [COORD_WIDTH-1:0] cmem_q_reg;

    logic [DC_W-1:0]        dims_act;
    logic [DI_W-1:0]        dim_last;
    logic [CI_W-1:0]        center_last;
    logic                   in_acc;
    logic                   first_in;
    logic [DI_W-1:0]        in_idx;
    logic                   point_done;
    logic [HC_W-1:0]        held_eff;
    logic                   emit_go;
    logic                   scan_end;
    logic                   store_end;
    dist_res_t              res;

    // A dimension count of zero acts as one; one beyond the buffer is capped.
    always_comb begin
        if (dims_reg == '0) begin
            dims_act = DC_W'(1);
        end else if (int'(dims_reg) > MAX_DIM) begin
            dims_act = DC_W'(MAX_DIM);
        end else begin
            dims_act = DC_W'(dims_reg);
        end
    end

    assign dim_last    = DI_W'(dims_act - DC_W'(1));
    assign center_last = CI_W'(held_reg - HC_W'(1));

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign first_in  = s_tuser[0];

    // A set start drops any partial point and restarts at coordinate zero.
    assign in_idx     = first_in ? '0 : coord_cnt_reg;
    assign point_done = !(in_idx < dim_last);
    assign held_eff   = first_in ? '0 : held_reg;

    assign scan_end  = (scan_c_reg == center_last) && (scan_i_reg == dim_last);
    assign store_end = (store_i_reg == DI_W'(MAX_DIM - 1));
    assign emit_go   = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && point_done) begin
                    state_next = (held_eff == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (res.valid && res.last_center) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (far_reg && (held_reg < HC_W'(MAX_CENTERS))) begin
                    state_next = S_STORE;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_STORE: begin
                if (store_end) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Tags for the element that the scan issues this cycle.
    always_comb begin
        ctl_b_next = '0;
        if (state_reg == S_SCAN) begin
            ctl_b_next.valid       = 1'b1;
            ctl_b_next.first_dim   = (scan_i_reg == '0);
            ctl_b_next.last_dim    = (scan_i_reg == dim_last);
            ctl_b_next.last_center = (scan_c_reg == center_last);
        end
    end

    // Result word as it will be loaded into the output register.
    always_comb begin
        m_tdata_next                       = '0;
        m_tdata_next[BIT_KEPT]             = kept_reg;
        m_tdata_next[BIT_COUNT +: COUNT_W] = COUNT_W'(held_reg);
        m_tdata_next[BIT_FULL]             = full_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            eps_reg       <= '0;
            dims_reg      <= DIMS_W'(1);
            coord_cnt_reg <= '0;
            held_reg      <= '0;
            scan_c_reg    <= '0;
            scan_i_reg    <= '0;
            store_i_reg   <= '0;
            far_reg       <= 1'b0;
            kept_reg      <= 1'b0;
            full_reg      <= 1'b0;
            ctl_b_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_EPS_SQUARED: eps_reg  <= cfg_data[EPS_W-1:0];
                    REG_DIMS_IN_USE: dims_reg <= cfg_data[DIMS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_acc) begin
                if (first_in) begin
                    held_reg <= '0;
                end
                if (point_done) begin
                    coord_cnt_reg <= '0;
                    far_reg       <= 1'b1;
                    scan_c_reg    <= '0;
                    scan_i_reg    <= '0;
                end else begin
                    coord_cnt_reg <= in_idx + 1'b1;
                end
            end

            // One element of the scan is issued each cycle.
            ctl_b_reg <= ctl_b_next;
            if (state_reg == S_SCAN) begin
                if (scan_i_reg == dim_last) begin
                    scan_i_reg <= '0;
                    scan_c_reg <= scan_c_reg + 1'b1;
                end else begin
                    scan_i_reg <= scan_i_reg + 1'b1;
                end
            end

            // Any center within the threshold vetoes the point.
            if (res.valid && !res.far) begin
                far_reg <= 1'b0;
            end

            if (state_reg == S_DECIDE) begin
                kept_reg    <= far_reg && (held_reg < HC_W'(MAX_CENTERS));
                full_reg    <= far_reg && !(held_reg < HC_W'(MAX_CENTERS));
                store_i_reg <= '0;
            end

            if (state_reg == S_STORE) begin
                store_i_reg <= store_i_reg + 1'b1;
                if (store_end) begin
                    held_reg <= held_reg + 1'b1;
                end
            end

            if ((state_reg == S_EMIT) && emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pbuf_reg[in_idx] <= s_tdata[COORD_WIDTH-1:0];
        end
        pt_i_reg <= scan_i_reg;
        if ((state_reg == S_EMIT) && emit_go) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Center memory: a new center is written one coordinate per cycle, with
    // zeros past the dimensions in use; the scan reads one coordinate per cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == S_STORE) begin
            cmem[{held_reg[CI_W-1:0], store_i_reg}] <=
                (DC_W'(store_i_reg) < dims_act) ? pbuf_reg[store_i_reg] : '0;
        end
        if (state_reg == S_SCAN) begin
            cmem_q_reg <= cmem[{scan_c_reg, scan_i_reg}];
        end
    end

    lcc_dist_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_i    (ctl_b_reg),
        .point_i  (pbuf_reg[pt_i_reg]),
        .center_i (cmem_q_reg),
        .eps_i    (eps_reg),
        .res_o    (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `include "assert_macros.svh"

    `ASSERT_SYNC(a_held_bound, held_reg <= HC_W'(MAX_CENTERS), "center count beyond store size")
    `ASSERT_SYNC(a_store_room, (state_reg == S_STORE) |-> (held_reg < HC_W'(MAX_CENTERS)), "store write with no room")
    `ASSERT_SYNC(a_res_in_scan, res.valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN), "distance verdict outside scan")
    `ASSERT_SYNC(a_kept_full, m_tvalid_reg |-> !(m_tdata_reg[BIT_KEPT] && m_tdata_reg[BIT_FULL]), "kept and store_full both set")

endmodule

// ----- tb/lcc_checker.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// lcc_checker
// Watches the coordinate, result and register channels of the clustering
// block, predicts every result word and compares it field by field.
//------------------------------------------------------------------------------
module lcc_checker
    import lcc_pkg::*;
#(
    parameter int MAX_CENTERS = 64,
    parameter int MAX_DIM     = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [((COORD_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    input  logic [0:0]                             s_tuser,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [OUT_W-1:0]                       m_tdata,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DAT_W-1:0]                   cfg_data,
    output int                                     failures,
    output int                                     awaiting
);

    typedef struct packed {
        logic               full;
        logic [COUNT_W-1:0] count;
        logic               kept;
    } verdict_t;

    logic [EPS_W-1:0]             eps_limit;
    logic [DIMS_W-1:0]            dims_setting;
    logic signed [COORD_WIDTH-1:0] point_coord [MAX_DIM];
    logic signed [COORD_WIDTH-1:0] center_coord [MAX_CENTERS][MAX_DIM];
    int                           centers_held;
    int                           coord_pos;
    verdict_t                     expected_verdicts [$];
    verdict_t                     want;
    verdict_t                     got;

    // Exact squared distance from the buffered point to one center.
    function automatic logic [ACC_W-1:0] squared_distance(input int c, input int dims);
        logic [ACC_W-1:0]              acc;
        logic [ACC_W:0]                total;
        logic signed [COORD_WIDTH:0]   diff;
        logic [2*COORD_WIDTH+1:0]      sq;
        acc = '0;
        for (int i = 0; i < dims; i++) begin
            diff  = point_coord[i] - center_coord[c][i];
            sq    = diff * diff;
            total = {1'b0, acc} + sq;
            acc   = total[ACC_W] ? {ACC_W{1'b1}} : total[ACC_W-1:0];
        end
        return acc;
    endfunction

    // Takes one accepted coordinate; queues a verdict when it closes a point.
    function automatic void cluster_point_word(input logic [COORD_WIDTH-1:0] coord,
                                               input logic fresh_set);
        int       dims;
        int       idx;
        bit       far_enough;
        verdict_t v;
        dims = (dims_setting == 0) ? 1 :
               (int'(dims_setting) > MAX_DIM) ? MAX_DIM : int'(dims_setting);
        if (fresh_set) begin
            centers_held = 0;
            coord_pos    = 0;
        end
        idx = (coord_pos >= MAX_DIM) ? MAX_DIM - 1 : coord_pos;
        point_coord[idx] = coord;
        if (idx + 1 < dims) begin
            coord_pos = idx + 1;
            return;
        end
        coord_pos  = 0;
        far_enough = 1'b1;
        for (int c = 0; c < centers_held; c++) begin
            if (!(squared_distance(c, dims) > eps_limit)) far_enough = 1'b0;
        end
        v = '0;
        if (far_enough) begin
            if (centers_held < MAX_CENTERS) begin
                for (int i = 0; i < MAX_DIM; i++)
                    center_coord[centers_held][i] = (i < dims) ? point_coord[i] : '0;
                centers_held++;
                v.kept = 1'b1;
            end else begin
                v.full = 1'b1;
            end
        end
        v.count = COUNT_W'(centers_held);
        expected_verdicts = {expected_verdicts, v};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            eps_limit    = '0;
            dims_setting = DIMS_W'(1);
            centers_held = 0;
            coord_pos    = 0;
            failures     = 0;
            expected_verdicts.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_EPS_SQUARED) begin
                    eps_limit = cfg_data[EPS_W-1:0];
                end else if (cfg_index == REG_DIMS_IN_USE) begin
                    dims_setting = cfg_data[DIMS_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got.kept  = m_tdata[BIT_KEPT];
                got.count = m_tdata[BIT_COUNT +: COUNT_W];
                got.full  = m_tdata[BIT_FULL];
                if (expected_verdicts.size() == 0) begin
                    $error("result word 0x%0h arrived with no point pending", m_tdata);
                    failures++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.kept !== want.kept) begin
                        $error("kept: expected %0d, actual %0d", want.kept, got.kept);
                        failures++;
                    end
                    if (got.count !== want.count) begin
                        $error("center_count: expected %0d, actual %0d",
                               want.count, got.count);
                        failures++;
                    end
                    if (got.full !== want.full) begin
                        $error("store_full: expected %0d, actual %0d", want.full, got.full);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                cluster_point_word(s_tdata[COORD_WIDTH-1:0], s_tuser[0]);
        end
        awaiting = expected_verdicts.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Regression for the leader clustering block: a directed opening, then phases
// of random point sets under changing thresholds and dimensions, with random
// stalls on both channels and results checked by a predicting checker.
//------------------------------------------------------------------------------
module tb;
    import lcc_pkg::*;

    localparam int MAX_CENTERS = 64;
    localparam int MAX_DIM     = 16;
    localparam int COORD_WIDTH = 16;
    localparam int SD_W        = ((COORD_WIDTH + 7) / 8) * 8;

    // Number of random coordinate words to send after the directed part.
    localparam int RANDOM_WORDS = 580;
    // Quiet cycles before a register write; a word that closes no point
    // leaves the block idle, so this is ample.
    localparam int QUIET = 40;
    // Tail after the last result: a full scan of the store plus a center write.
    localparam int TAIL = MAX_CENTERS * MAX_DIM + MAX_DIM + 16;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // Bits from lowest: coordinate (COORD_WIDTH, signed), zero fill.
    logic [SD_W-1:0]        s_tdata;
    // Bit 0: first_of_set.
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // Bits from lowest: kept (1), center_count (7), store_full (1), zero fill.
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_data;

    int                     failures;
    int                     awaiting;

    // When set, neither side inserts idle cycles.
    bit                     steady;
    int                     words_sent;
    // Last dims_in_use written, used only to shape the stimulus.
    logic [DIMS_W-1:0]      dims_now;

    leader_clustering_centers #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIM     (MAX_DIM),
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcc_checker #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIM     (MAX_DIM),
        .COORD_WIDTH (COORD_WIDTH)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .awaiting  (awaiting)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // A coordinate near base within +/- spread; a full spread means any value.
    // The two extremes are mixed in on purpose.
    function automatic logic [COORD_WIDTH-1:0] pick_coord(input logic [COORD_WIDTH-1:0] base,
                                                          input int spread);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        if (r < 6) return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        if (spread >= 32768) return COORD_WIDTH'($urandom);
        return base + COORD_WIDTH'($urandom_range(0, 2 * spread)) - COORD_WIDTH'(spread);
    endfunction

    // Offers one coordinate word and returns at the edge that accepts it.
    // tvalid stays high on return so back-to-back words need no second
    // assignment in the same step.
    task automatic send_word(input logic [COORD_WIDTH-1:0] coord, input logic fresh_set);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= SD_W'(coord);
        s_tuser  <= fresh_set;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // One register write; the caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_DIMS_IN_USE) dims_now = val[DIMS_W-1:0];
    endtask

    // Stops the input, waits for every predicted result word, then lets the
    // block settle so that a register write finds it idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaiting != 0);
        repeat (QUIET) @(posedge aclk);
    endtask

    // One random phase: new settings, then point sets. With fill_store the
    // phase uses one coordinate per point, a zero threshold and one long set
    // of scattered points, which runs the center store full.
    task automatic random_phase(input bit fill_store);
        logic [DIMS_W-1:0]      dims_val;
        logic [CFG_DAT_W-1:0]   eps_val;
        logic [CFG_DAT_W-1:0]   junk;
        logic [COORD_WIDTH-1:0] base;
        int                     eff, spread, budget, start, npts, r;
        bit                     do_eps, do_dims, first_set, restart;

        r = $urandom_range(0, 99);
        if (fill_store)  dims_val = DIMS_W'(1);
        else if (r < 40) dims_val = DIMS_W'($urandom_range(1, 3));
        else if (r < 70) dims_val = DIMS_W'($urandom_range(4, 8));
        else if (r < 85) dims_val = DIMS_W'($urandom_range(9, MAX_DIM));
        else if (r < 92) dims_val = '0;
        else             dims_val = DIMS_W'($urandom_range(MAX_DIM + 1, 31));

        case ($urandom_range(0, 3))
            0:       spread = 32768;
            1:       spread = $urandom_range(1, 16);
            2:       spread = $urandom_range(64, 1024);
            default: spread = 8192;
        endcase
        if (fill_store) spread = 32768;

        do_dims = fill_store || ($urandom_range(0, 9) != 0);
        do_eps  = fill_store || ($urandom_range(0, 9) != 0);
        if (do_dims) begin
            eff = (dims_val == 0) ? 1 : (int'(dims_val) > MAX_DIM) ? MAX_DIM : int'(dims_val);
        end else begin
            eff = (dims_now == 0) ? 1 : (int'(dims_now) > MAX_DIM) ? MAX_DIM : int'(dims_now);
        end

        // Thresholds: none, the largest, any, or one scaled to the spread
        // of the points so that some points land on each side of it.
        case ($urandom_range(0, 4))
            0:       eps_val = '0;
            1:       eps_val = '1;
            2:       eps_val = CFG_DAT_W'({$urandom, $urandom});
            default: eps_val = CFG_DAT_W'(longint'(eff) * spread * spread
                                          * $urandom_range(1, 6) / 2);
        endcase
        if (fill_store) eps_val = '0;

        // Bits above the dims field are random; only the low five count.
        junk = CFG_DAT_W'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 1) begin
            if (do_dims) write_reg(REG_DIMS_IN_USE, {junk[CFG_DAT_W-1:DIMS_W], dims_val});
            if (do_eps)  write_reg(REG_EPS_SQUARED, eps_val);
        end else begin
            if (do_eps)  write_reg(REG_EPS_SQUARED, eps_val);
            if (do_dims) write_reg(REG_DIMS_IN_USE, {junk[CFG_DAT_W-1:DIMS_W], dims_val});
        end
        // Now and then a write to an index that holds no register.
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)), junk);
        cfg_valid <= 1'b0;

        steady    = ($urandom_range(0, 3) == 0);
        budget    = fill_store ? $urandom_range(90, 120) : $urandom_range(30, 90);
        start     = words_sent;
        // Sometimes the phase continues the set, and any partial point,
        // left over from the phase before.
        first_set = (!fill_store && $urandom_range(0, 3) == 0);
        base      = COORD_WIDTH'($urandom);
        while (words_sent - start < budget) begin
            base = COORD_WIDTH'($urandom);
            npts = fill_store ? budget : $urandom_range(1, 20);
            for (int p = 0; p < npts && words_sent - start < budget; p++) begin
                for (int d = 0; d < eff; d++) begin
                    // A stray set start now and then breaks a point in half.
                    restart = (p == 0 && d == 0 && !first_set) ||
                              (!fill_store && $urandom_range(0, 99) < 2);
                    send_word(pick_coord(base, spread), restart);
                end
            end
            first_set = 1'b0;
        end
        // Leave a partial point behind for the next settings to finish.
        if (!fill_store && eff > 1 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, eff - 1)) send_word(pick_coord(base, spread), 1'b0);
        drain_results();
    endtask

    // Result side: ready in bursts, with idle stretches between them.
    initial begin
        int g;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin
        int fixed_words;
        steady     = 1'b0;
        words_sent = 0;
        dims_now   = DIMS_W'(1);
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero threshold, one coordinate per point. These
        // words come before any set start, so the block treats them as a
        // set opened by reset. A repeat of a center is not kept; the
        // extremes of the coordinate range are.
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        // A set start clears the store, so the same point is kept again.
        send_word(16'h7FFF, 1'b1);
        send_word(16'h7FFF, 1'b0);
        drain_results();

        // Largest threshold: only the first point of a set is ever kept.
        // The dims write carries ones above its five valid bits.
        write_reg(REG_EPS_SQUARED, '1);
        write_reg(REG_DIMS_IN_USE, {{(CFG_DAT_W-DIMS_W){1'b1}}, DIMS_W'(2)});
        cfg_valid <= 1'b0;
        send_word(16'd5, 1'b1);
        send_word(16'hFFFB, 1'b0);
        send_word(16'd100, 1'b0);
        send_word(16'd200, 1'b0);
        // A set start on the second coordinate drops the half point.
        send_word(16'd1, 1'b0);
        send_word(16'd2, 1'b1);
        send_word(16'd3, 1'b0);
        // Half a point, then the point grows to three coordinates.
        send_word(16'd7, 1'b0);
        drain_results();

        write_reg(REG_EPS_SQUARED, '0);
        write_reg(REG_DIMS_IN_USE, CFG_DAT_W'(3));
        cfg_valid <= 1'b0;
        send_word(16'd8, 1'b0);
        send_word(16'd9, 1'b0);
        drain_results();

        // A dims setting of zero behaves as one; stored centers are now
        // compared on their first coordinate only.
        write_reg(REG_DIMS_IN_USE, CFG_DAT_W'(0));
        cfg_valid <= 1'b0;
        send_word(16'd4, 1'b0);
        send_word(16'd4, 1'b0);
        drain_results();

        // Random part, opened by a phase that overflows the center store.
        fixed_words = words_sent;
        random_phase(1'b1);
        while (words_sent - fixed_words < RANDOM_WORDS)
            random_phase(1'b0);

        // Any stray result word would show up within this tail.
        repeat (TAIL) @(posedge aclk);
        if (failures == 0 && awaiting == 0) begin
            $display("leader_clustering_centers regression: pass");
        end else begin
            $display("leader_clustering_centers regression: fail");
        end
        $finish;
    end

    // Hard stop, well beyond the slowest correct run.
    initial begin
        #25_000_000;
        $display("leader_clustering_centers regression: fail");
        $finish;
    end

endmodule
